// ----- sv/ssds_pkg.sv -----
package ssds_pkg;

    localparam int STEP_W = 5;
    typedef logic [STEP_W-1:0] t_step;

    // sequencer steps
    localparam t_step ST_IDLE = 5'd0;
    localparam t_step ST_I0   = 5'd1;
    localparam t_step ST_I1   = 5'd2;
    localparam t_step ST_I2   = 5'd3;
    localparam t_step ST_S0   = 5'd4;
    localparam t_step ST_S1   = 5'd5;
    localparam t_step ST_S2   = 5'd6;
    localparam t_step ST_B0   = 5'd7;
    localparam t_step ST_B1   = 5'd8;
    localparam t_step ST_B2   = 5'd9;
    localparam t_step ST_B3   = 5'd10;
    localparam t_step ST_A0   = 5'd11;
    localparam t_step ST_A1   = 5'd12;
    localparam t_step ST_A2   = 5'd13;
    localparam t_step ST_A3   = 5'd14;
    localparam t_step ST_D0   = 5'd15;
    localparam t_step ST_D1   = 5'd16;
    localparam t_step ST_D2   = 5'd17;

    // sequence commands
    localparam logic [2:0] CMD_INIT   = 3'd0;
    localparam logic [2:0] CMD_STEADY = 3'd1;
    localparam logic [2:0] CMD_BLINK  = 3'd2;
    localparam logic [2:0] CMD_ADJUST = 3'd3;
    localparam logic [2:0] CMD_DETECT = 3'd4;

    // tick counter operations
    localparam logic [1:0] TICK_HOLD = 2'd0;
    localparam logic [1:0] TICK_CLR  = 2'd1;
    localparam logic [1:0] TICK_INC  = 2'd2;
    localparam logic [1:0] TICK_ONE  = 2'd3;

    // led operations
    localparam logic [1:0] LED_HOLD = 2'd0;
    localparam logic [1:0] LED_ON   = 2'd1;
    localparam logic [1:0] LED_OFF  = 2'd2;

    // debounce checks
    localparam logic [1:0] CHK_NONE  = 2'd0;
    localparam logic [1:0] CHK_FULL  = 2'd1;
    localparam logic [1:0] CHK_FIRST = 2'd2;

    // jump conditions
    localparam logic [1:0] COND_ALWAYS  = 2'd0;
    localparam logic [1:0] COND_SAMPLES = 2'd1;
    localparam logic [1:0] COND_OFF     = 2'd2;
    localparam logic [1:0] COND_DIFF    = 2'd3;

    // configuration register indexes
    localparam logic [1:0] REG_TRACKED = 2'd0;
    localparam logic [1:0] REG_VALID   = 2'd1;
    localparam logic [1:0] REG_CENTER  = 2'd2;

    typedef struct packed {
        logic       take;
        logic       intr;
        logic [1:0] tick_op;
        logic [1:0] led_op;
        logic [1:0] chk;
        logic       chk_hit;
        logic [1:0] cond;
        logic       hit_tclr;
        logic       miss_tclr;
        logic [1:0] hit_led;
        logic [1:0] miss_led;
        logic       ev_init;
        logic       ev_bcast;
        logic       ev_adj;
        logic       adj_latch;
        logic       slide;
        t_step      hit_step;
        t_step      miss_step;
    } t_ucode;

    typedef struct packed {
        logic        mode;
        logic [2:0]  seq_cmd;
        logic [15:0] off_ticks;
        logic [15:0] sensor_sample;
        logic [1:0]  validation_bits;
    } t_in_item;

    typedef struct packed {
        logic        led_on;
        logic        intr_enable;
        logic        sample_taken;
        logic        shift_event;
        logic        init_event;
        logic        adjust_event;
        logic        broadcast_event;
        logic [15:0] debounced_state;
        logic [15:0] adjust_value;
        logic        centering_home_out;
    } t_out_item;

    function automatic t_step start_step(input logic [2:0] cmd);
        t_step st;
        case (cmd)
            CMD_INIT:   st = ST_I0;
            CMD_STEADY: st = ST_S0;
            CMD_BLINK:  st = ST_B0;
            CMD_ADJUST: st = ST_A0;
            CMD_DETECT: st = ST_D0;
            default:    st = ST_IDLE;
        endcase
        return st;
    endfunction

    // microcode store: one control word per step
    function automatic t_ucode ucode(input t_step step);
        t_ucode uc;
        uc           = '0;
        uc.hit_step  = step;
        uc.miss_step = step;
        case (step)
            ST_I0, ST_S0, ST_A0, ST_D0: begin
                uc.led_op   = LED_ON;
                uc.tick_op  = TICK_CLR;
                uc.hit_step = t_step'(step + 5'd1);
            end
            ST_I1, ST_S1, ST_A1, ST_D1: begin
                uc.intr     = 1'b1;
                uc.take     = 1'b1;
                uc.tick_op  = TICK_INC;
                uc.hit_step = t_step'(step + 5'd1);
            end
            ST_I2: begin
                uc.take     = 1'b1;
                uc.tick_op  = TICK_INC;
                uc.cond     = COND_SAMPLES;
                uc.hit_tclr = 1'b1;
                uc.chk      = CHK_FULL;
                uc.chk_hit  = 1'b1;
                uc.ev_init  = 1'b1;
                uc.hit_step = ST_S2;
            end
            ST_S2: begin
                uc.take     = 1'b1;
                uc.tick_op  = TICK_INC;
                uc.cond     = COND_SAMPLES;
                uc.hit_tclr = 1'b1;
                uc.chk      = CHK_FULL;
                uc.chk_hit  = 1'b1;
                uc.ev_bcast = 1'b1;
            end
            ST_B0: begin
                uc.led_op   = LED_OFF;
                uc.tick_op  = TICK_CLR;
                uc.hit_step = ST_B1;
            end
            ST_B1: begin
                uc.tick_op  = TICK_INC;
                uc.cond     = COND_OFF;
                uc.hit_tclr = 1'b1;
                uc.hit_led  = LED_ON;
                uc.hit_step = ST_B2;
            end
            ST_B2: begin
                uc.intr      = 1'b1;
                uc.take      = 1'b1;
                uc.tick_op   = TICK_INC;
                uc.chk       = CHK_FIRST;
                uc.cond      = COND_DIFF;
                uc.hit_step  = ST_B3;
                uc.miss_led  = LED_OFF;
                uc.miss_tclr = 1'b1;
                uc.miss_step = ST_B1;
            end
            ST_B3: begin
                uc.take     = 1'b1;
                uc.chk      = CHK_FULL;
                uc.led_op   = LED_OFF;
                uc.tick_op  = TICK_CLR;
                uc.hit_step = ST_B1;
            end
            ST_A2: begin
                uc.take      = 1'b1;
                uc.tick_op   = TICK_INC;
                uc.cond      = COND_SAMPLES;
                uc.hit_tclr  = 1'b1;
                uc.adj_latch = 1'b1;
                uc.ev_adj    = 1'b1;
                uc.hit_step  = ST_A3;
            end
            ST_D2: begin
                uc.take    = 1'b1;
                uc.chk     = CHK_FULL;
                uc.slide   = 1'b1;
                uc.tick_op = TICK_ONE;
                uc.ev_adj  = 1'b1;
            end
            default: begin
                uc.tick_op = TICK_HOLD;
            end
        endcase
        return uc;
    endfunction

endpackage

// ----- sv/ssds_ifs.sv -----
interface ssds_in_if;
    logic                 valid;
    logic                 ready;
    ssds_pkg::t_in_item   payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface ssds_out_if;
    logic                 valid;
    logic                 ready;
    ssds_pkg::t_out_item  payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ----- sv/strobed_sensor_debounce_sequencer_core.sv -----
// Tick-driven LED strobe and debounce sequencer for a position sensor. Each input
// transaction is either a sequence command (mode 1), which is held pending and takes
// effect at the next tick, or a timer tick (mode 0), which runs one step of the active
// sequence: init, steady on, blink, position adjust or adjust detect. Every input
// transaction produces exactly one output transaction carrying the LED level, the
// event pulses and the debounced word. The step counter selects a control word from
// the microcode store in ssds_pkg and the whole step, including the compare over all
// SAMPLES stored words, is combinational, so with the output taken promptly a new
// transaction is accepted every cycle. The output register decouples the two
// channels; input ready drops only while a result waits. Configuration (tracked,
// validation and centering-home masks at byte addresses 0, 4 and 8) is written over
// the APB port by the user while the block is idle; the block does not enforce it.
module strobed_sensor_debounce_sequencer_core #(
    parameter int SAMPLES = 2
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    ssds_in_if.sink               i_in,
    ssds_out_if.source            o_out,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [3:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    localparam int IDX_W = $clog2(SAMPLES);

    logic [15:0]          r_tracked;
    logic [15:0]          r_valmask;
    logic [15:0]          r_center;

    ssds_pkg::t_step      r_step, n_step;
    logic [15:0]          r_tick, n_tick;
    logic [15:0]          r_store [SAMPLES];
    logic [15:0]          n_store [SAMPLES];
    logic [15:0]          r_deb, n_deb;
    logic [15:0]          r_off, n_off;
    logic                 r_pend_valid, n_pend_valid;
    logic [2:0]           r_pend_cmd, n_pend_cmd;
    logic [15:0]          r_pend_off, n_pend_off;
    logic [15:0]          r_adj, n_adj;
    logic                 r_clevel, n_clevel;
    logic                 r_led, n_led;
    logic                 r_out_valid;
    ssds_pkg::t_out_item  r_out, n_out;

    logic                 acc;
    logic                 is_tick;
    ssds_pkg::t_in_item   item;
    ssds_pkg::t_step      eff_step;
    logic [15:0]          eff_off;
    ssds_pkg::t_ucode     uc;
    logic [15:0]          tick_base;
    logic                 take_ok;
    logic [IDX_W-1:0]     idx;
    logic [15:0]          s_take [SAMPLES];
    logic [15:0]          all_diff;
    logic                 first_diff;
    logic                 hit;
    logic                 do_full;
    logic                 do_first;
    logic [15:0]          deb_pre;
    logic [15:0]          cen_a, cen_b;
    logic                 shift;

    assign pready = 1'b1;

    always_comb begin
        case (paddr[3:2])
            ssds_pkg::REG_TRACKED: prdata = {16'd0, r_tracked};
            ssds_pkg::REG_VALID:   prdata = {16'd0, r_valmask};
            ssds_pkg::REG_CENTER:  prdata = {16'd0, r_center};
            default:               prdata = 32'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tracked <= 16'h03FF;
            r_valmask <= 16'h0400;
            r_center  <= 16'h0080;
        end else if (psel && penable && pwrite && pready) begin
            case (paddr[3:2])
                ssds_pkg::REG_TRACKED: r_tracked <= pwdata[15:0];
                ssds_pkg::REG_VALID:   r_valmask <= pwdata[15:0];
                ssds_pkg::REG_CENTER:  r_center  <= pwdata[15:0];
                default: begin
                end
            endcase
        end
    end

    assign item        = i_in.payload;
    assign i_in.ready  = !r_out_valid || o_out.ready;
    assign acc         = i_in.valid && i_in.ready;
    assign is_tick     = acc && !item.mode;
    assign o_out.valid = r_out_valid;
    assign o_out.payload = r_out;

    // a pending command restarts the sequence at the start of this tick
    assign eff_step = r_pend_valid ? ssds_pkg::start_step(r_pend_cmd) : r_step;
    assign eff_off  = r_pend_valid ? r_pend_off : r_off;
    assign uc       = ssds_pkg::ucode(eff_step);

    always_comb begin
        case (uc.tick_op)
            ssds_pkg::TICK_CLR: tick_base = 16'd0;
            ssds_pkg::TICK_INC: tick_base = r_tick + 16'd1;
            ssds_pkg::TICK_ONE: tick_base = 16'd1;
            default:            tick_base = r_tick;
        endcase
    end

    assign take_ok = uc.take && (r_tick < 16'(SAMPLES));
    assign idx     = r_tick[IDX_W-1:0];

    always_comb begin
        all_diff = r_tracked;
        for (int i = 0; i < SAMPLES; i++) begin
            s_take[i] = (take_ok && idx == IDX_W'(i)) ? item.sensor_sample : r_store[i];
            all_diff  = all_diff & (s_take[i] ^ r_deb);
        end
    end

    assign first_diff = ((s_take[0] ^ r_deb) & r_tracked) != 16'd0;

    always_comb begin
        case (uc.cond)
            ssds_pkg::COND_SAMPLES: hit = tick_base >= 16'(SAMPLES);
            ssds_pkg::COND_OFF:     hit = tick_base >= eff_off;
            ssds_pkg::COND_DIFF:    hit = first_diff;
            default:                hit = 1'b1;
        endcase
    end

    assign do_full  = (uc.chk == ssds_pkg::CHK_FULL) && (!uc.chk_hit || hit);
    assign do_first = (uc.chk == ssds_pkg::CHK_FIRST);
    assign deb_pre  = do_full ? (r_deb ^ all_diff) : r_deb;
    assign cen_a    = s_take[0] & r_center;
    assign cen_b    = s_take[1] & r_center;
    assign shift    = do_full && (all_diff != 16'd0);

    always_comb begin
        n_step       = r_step;
        n_tick       = r_tick;
        n_deb        = r_deb;
        n_off        = r_off;
        n_pend_valid = r_pend_valid;
        n_pend_cmd   = r_pend_cmd;
        n_pend_off   = r_pend_off;
        n_adj        = r_adj;
        n_clevel     = r_clevel;
        n_led        = r_led;
        for (int i = 0; i < SAMPLES; i++) begin
            n_store[i] = r_store[i];
        end

        if (acc && item.mode) begin
            if (item.seq_cmd <= ssds_pkg::CMD_DETECT) begin
                n_pend_valid = 1'b1;
                n_pend_cmd   = item.seq_cmd;
                n_pend_off   = item.off_ticks;
            end else begin
                n_pend_valid = 1'b0;
            end
        end else if (is_tick) begin
            n_pend_valid = 1'b0;
            n_off        = eff_off;
            n_step       = hit ? uc.hit_step : uc.miss_step;

            n_tick = tick_base;
            if (hit ? uc.hit_tclr : uc.miss_tclr) begin
                n_tick = 16'd0;
            end

            case (uc.led_op)
                ssds_pkg::LED_ON:  n_led = 1'b1;
                ssds_pkg::LED_OFF: n_led = 1'b0;
                default:           n_led = r_led;
            endcase
            case (hit ? uc.hit_led : uc.miss_led)
                ssds_pkg::LED_ON:  n_led = 1'b1;
                ssds_pkg::LED_OFF: n_led = 1'b0;
                default: begin
                end
            endcase

            for (int i = 0; i < SAMPLES; i++) begin
                n_store[i] = s_take[i];
            end
            // adjust detect slides the two-sample window
            if (uc.slide) begin
                n_store[0] = s_take[1];
            end

            n_deb = deb_pre;
            if (do_full || do_first) begin
                if (item.validation_bits == 2'b11) begin
                    n_deb = deb_pre | r_valmask;
                end else begin
                    n_deb = deb_pre & ~r_valmask;
                end
            end
            if (do_full && cen_a == cen_b) begin
                n_clevel = (cen_a == 16'd0);
            end

            if (uc.adj_latch && hit) begin
                n_adj = s_take[SAMPLES-1];
            end
        end
    end

    always_comb begin
        n_out.led_on             = n_led;
        n_out.intr_enable        = is_tick && uc.intr;
        n_out.sample_taken       = is_tick && take_ok;
        n_out.shift_event        = is_tick && shift;
        n_out.init_event         = is_tick && uc.ev_init && hit;
        n_out.adjust_event       = is_tick && uc.ev_adj && hit;
        n_out.broadcast_event    = is_tick && uc.ev_bcast && shift;
        n_out.debounced_state    = n_deb;
        n_out.adjust_value       = n_adj;
        n_out.centering_home_out = n_clevel;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step       <= ssds_pkg::ST_IDLE;
            r_tick       <= 16'd0;
            r_deb        <= 16'd0;
            r_off        <= 16'd0;
            r_pend_valid <= 1'b0;
            r_pend_cmd   <= ssds_pkg::CMD_INIT;
            r_pend_off   <= 16'd0;
            r_adj        <= 16'd0;
            r_clevel     <= 1'b0;
            r_led        <= 1'b0;
            r_out_valid  <= 1'b0;
            for (int i = 0; i < SAMPLES; i++) begin
                r_store[i] <= 16'd0;
            end
        end else begin
            if (acc) begin
                r_step       <= n_step;
                r_tick       <= n_tick;
                r_deb        <= n_deb;
                r_off        <= n_off;
                r_pend_valid <= n_pend_valid;
                r_pend_cmd   <= n_pend_cmd;
                r_pend_off   <= n_pend_off;
                r_adj        <= n_adj;
                r_clevel     <= n_clevel;
                r_led        <= n_led;
                for (int i = 0; i < SAMPLES; i++) begin
                    r_store[i] <= n_store[i];
                end
            end
            if (acc) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_out <= n_out;
        end
    end

`ifndef SYNTHESIS
    a_pend_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        is_tick |=> !r_pend_valid)
        else $error("pending command survived a tick");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc |=> r_out_valid)
        else $error("accepted transaction produced no result");

    a_cmd_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && item.mode) |=> (!r_out.sample_taken && !r_out.intr_enable
            && !r_out.shift_event && !r_out.adjust_event))
        else $error("command transaction reported tick activity");

    a_detect_slide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (is_tick && eff_step == ssds_pkg::ST_D2) |=>
            (r_tick == 16'd1 && r_step == ssds_pkg::ST_D2 && r_store[0] == r_store[1]))
        else $error("adjust detect window did not slide");

    a_bcast_shift: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (is_tick && eff_step != ssds_pkg::ST_S2) |=> !r_out.broadcast_event)
        else $error("broadcast outside steady sequence");
`endif

endmodule

// ----- tb/ssds_status_checker.sv -----
`timescale 1ns / 100ps

module ssds_status_checker #(
    parameter int SAMPLES = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ssds_in_if          i_in,
    ssds_out_if         i_out,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic        i_pready,
    input  logic [3:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    output int          o_errors,
    output int          o_queued
);

    // register copies
    logic [15:0] trk_mask;
    logic [15:0] vld_mask;
    logic [15:0] ctr_mask;

    // sequencer state
    ssds_pkg::t_step step_q;
    logic [15:0] tick_q;
    logic [15:0] smp_mem [SAMPLES];
    logic [15:0] deb_q;
    logic [15:0] blink_off;
    logic        pend_vld;
    logic [2:0]  pend_cmd;
    logic [15:0] pend_off;
    logic [15:0] adj_q;
    logic        ctr_lvl;
    logic        led_q;

    ssds_pkg::t_out_item status_q [$];
    int          mismatch_count = 0;

    assign o_errors = mismatch_count;

    function automatic bit store_sample(input logic [15:0] s);
        if (tick_q < SAMPLES) begin
            smp_mem[tick_q] = s;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void set_validation(input logic [1:0] vb);
        if (vb == 2'b11)
            deb_q = deb_q | vld_mask;
        else
            deb_q = deb_q & ~vld_mask;
    endfunction

    // a tracked bit flips only when every stored sample disagrees with it
    function automatic bit full_compare(input logic [1:0] vb);
        logic [15:0] diff;
        logic [15:0] ca;
        logic [15:0] cb;
        diff = trk_mask;
        for (int k = 0; k < SAMPLES; k++)
            diff = diff & (smp_mem[k] ^ deb_q);
        deb_q = deb_q ^ diff;
        ca = smp_mem[0] & ctr_mask;
        cb = smp_mem[1] & ctr_mask;
        if (ca == cb)
            ctr_lvl = (ca == 16'h0000);
        set_validation(vb);
        return diff != 16'h0000;
    endfunction

    function automatic ssds_pkg::t_out_item run_sequencer(input ssds_pkg::t_in_item it);
        ssds_pkg::t_out_item r;
        logic [15:0] diff;
        r = '0;
        if (it.mode) begin
            if (it.seq_cmd <= ssds_pkg::CMD_DETECT) begin
                pend_vld = 1'b1;
                pend_cmd = it.seq_cmd;
                pend_off = it.off_ticks;
            end else begin
                pend_vld = 1'b0;
            end
        end else begin
            if (pend_vld) begin
                case (pend_cmd)
                    ssds_pkg::CMD_INIT:   step_q = ssds_pkg::ST_I0;
                    ssds_pkg::CMD_STEADY: step_q = ssds_pkg::ST_S0;
                    ssds_pkg::CMD_BLINK:  step_q = ssds_pkg::ST_B0;
                    ssds_pkg::CMD_ADJUST: step_q = ssds_pkg::ST_A0;
                    default:              step_q = ssds_pkg::ST_D0;
                endcase
                blink_off = pend_off;
                pend_vld  = 1'b0;
            end
            case (step_q)
                ssds_pkg::ST_I0, ssds_pkg::ST_S0,
                ssds_pkg::ST_A0, ssds_pkg::ST_D0: begin
                    led_q  = 1'b1;
                    tick_q = 16'h0000;
                    step_q = ssds_pkg::t_step'(step_q + 5'd1);
                end
                ssds_pkg::ST_I1, ssds_pkg::ST_S1,
                ssds_pkg::ST_A1, ssds_pkg::ST_D1: begin
                    r.intr_enable  = 1'b1;
                    r.sample_taken = store_sample(it.sensor_sample);
                    step_q = ssds_pkg::t_step'(step_q + 5'd1);
                    tick_q = tick_q + 16'd1;
                end
                ssds_pkg::ST_I2, ssds_pkg::ST_S2: begin
                    r.sample_taken = store_sample(it.sensor_sample);
                    tick_q = tick_q + 16'd1;
                    if (tick_q >= SAMPLES) begin
                        tick_q = 16'h0000;
                        r.shift_event = full_compare(it.validation_bits);
                        if (step_q == ssds_pkg::ST_I2) begin
                            r.init_event = 1'b1;
                            step_q = ssds_pkg::ST_S2;
                        end else begin
                            r.broadcast_event = r.shift_event;
                        end
                    end
                end
                ssds_pkg::ST_B0: begin
                    led_q  = 1'b0;
                    tick_q = 16'h0000;
                    step_q = ssds_pkg::ST_B1;
                end
                ssds_pkg::ST_B1: begin
                    tick_q = tick_q + 16'd1;
                    if (tick_q >= blink_off) begin
                        led_q  = 1'b1;
                        tick_q = 16'h0000;
                        step_q = ssds_pkg::ST_B2;
                    end
                end
                ssds_pkg::ST_B2: begin
                    r.intr_enable  = 1'b1;
                    r.sample_taken = store_sample(it.sensor_sample);
                    tick_q = tick_q + 16'd1;
                    // quick look at the first sample only
                    diff = (smp_mem[0] ^ deb_q) & trk_mask;
                    set_validation(it.validation_bits);
                    if (diff != 16'h0000) begin
                        step_q = ssds_pkg::ST_B3;
                    end else begin
                        led_q  = 1'b0;
                        tick_q = 16'h0000;
                        step_q = ssds_pkg::ST_B1;
                    end
                end
                ssds_pkg::ST_B3: begin
                    r.sample_taken = store_sample(it.sensor_sample);
                    r.shift_event  = full_compare(it.validation_bits);
                    led_q  = 1'b0;
                    tick_q = 16'h0000;
                    step_q = ssds_pkg::ST_B1;
                end
                ssds_pkg::ST_A2: begin
                    r.sample_taken = store_sample(it.sensor_sample);
                    tick_q = tick_q + 16'd1;
                    if (tick_q >= SAMPLES) begin
                        step_q = ssds_pkg::ST_A3;
                        tick_q = 16'h0000;
                        adj_q  = smp_mem[SAMPLES-1];
                        r.adjust_event = 1'b1;
                    end
                end
                ssds_pkg::ST_D2: begin
                    r.sample_taken = store_sample(it.sensor_sample);
                    r.shift_event  = full_compare(it.validation_bits);
                    smp_mem[0]     = smp_mem[1];
                    tick_q         = 16'd1;
                    r.adjust_event = 1'b1;
                end
                default: begin
                end
            endcase
        end
        r.led_on             = led_q;
        r.debounced_state    = deb_q;
        r.adjust_value       = adj_q;
        r.centering_home_out = ctr_lvl;
        return r;
    endfunction

    task automatic check_field(input string fname, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want) begin
            mismatch_count++;
            $display("%0t: %s mismatch, expected %h actual %h", $time, fname, want, got);
        end
    endtask

    always @(posedge i_clk) begin : watch
        ssds_pkg::t_out_item want;
        ssds_pkg::t_out_item got;
        if (!i_rst_n) begin
            trk_mask  = 16'h03FF;
            vld_mask  = 16'h0400;
            ctr_mask  = 16'h0080;
            step_q    = ssds_pkg::ST_IDLE;
            tick_q    = 16'h0000;
            for (int k = 0; k < SAMPLES; k++)
                smp_mem[k] = 16'h0000;
            deb_q     = 16'h0000;
            blink_off = 16'h0000;
            pend_vld  = 1'b0;
            pend_cmd  = ssds_pkg::CMD_INIT;
            pend_off  = 16'h0000;
            adj_q     = 16'h0000;
            ctr_lvl   = 1'b0;
            led_q     = 1'b0;
            status_q.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[3:2])
                    ssds_pkg::REG_TRACKED: trk_mask = i_pwdata[15:0];
                    ssds_pkg::REG_VALID:   vld_mask = i_pwdata[15:0];
                    ssds_pkg::REG_CENTER:  ctr_mask = i_pwdata[15:0];
                    default: begin
                    end
                endcase
            end
            if (i_in.valid && i_in.ready)
                status_q.push_back(run_sequencer(i_in.payload));
            if (i_out.valid && i_out.ready) begin
                got = i_out.payload;
                if (status_q.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: unexpected transaction, expected none actual %h",
                             $time, got);
                end else begin
                    want = status_q.pop_front();
                    check_field("led_on", want.led_on, got.led_on);
                    check_field("intr_enable", want.intr_enable, got.intr_enable);
                    check_field("sample_taken", want.sample_taken, got.sample_taken);
                    check_field("shift_event", want.shift_event, got.shift_event);
                    check_field("init_event", want.init_event, got.init_event);
                    check_field("adjust_event", want.adjust_event, got.adjust_event);
                    check_field("broadcast_event", want.broadcast_event,
                                got.broadcast_event);
                    check_field("debounced_state", want.debounced_state,
                                got.debounced_state);
                    check_field("adjust_value", want.adjust_value, got.adjust_value);
                    check_field("centering_home_out", want.centering_home_out,
                                got.centering_home_out);
                end
            end
        end
        o_queued = status_q.size();
    end

endmodule

// ----- tb/strobed_sensor_debounce_sequencer_core_tb.sv -----
`timescale 1ns / 100ps

module strobed_sensor_debounce_sequencer_core_tb;

    localparam int N_SAMPLES  = 2;
    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_CYCLES = 150;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int          errors;
    int          queued;
    int          tx_idle_pct = 6;
    int          rx_idle_pct = 66;
    bit          rx_hold = 1'b0;
    bit          pressure_on = 1'b0;

    ssds_in_if  in_ch ();
    ssds_out_if out_ch ();

    strobed_sensor_debounce_sequencer_core #(
        .SAMPLES (N_SAMPLES)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    ssds_status_checker #(
        .SAMPLES (N_SAMPLES)
    ) checker_i (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (in_ch),
        .i_out     (out_ch),
        .i_psel    (psel),
        .i_penable (penable),
        .i_pwrite  (pwrite),
        .i_pready  (pready),
        .i_paddr   (paddr),
        .i_pwdata  (pwdata),
        .o_errors  (errors),
        .o_queued  (queued)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // receiver side
    initial begin
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            out_ch.ready <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // long receiver hold-off so the block backs up into its input
    initial begin
        wait (pressure_on);
        repeat (40) @(negedge i_clk);
        rx_hold = 1'b1;
        repeat (HOLD_CYCLES) @(negedge i_clk);
        rx_hold = 1'b0;
    end

    initial begin : watchdog
        int stalled;
        stalled = 0;
        forever begin
            @(posedge i_clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                stalled = 0;
            else
                stalled++;
            if (stalled >= STALL_LIMIT) begin
                $display("strobed_sensor_debounce_sequencer_core verification failed");
                $finish;
            end
        end
    end

    function automatic ssds_pkg::t_in_item cmd_item(input logic [2:0] c,
                                                    input logic [15:0] off);
        ssds_pkg::t_in_item it;
        it.mode            = 1'b1;
        it.seq_cmd         = c;
        it.off_ticks       = off;
        it.sensor_sample   = 16'($urandom);
        it.validation_bits = 2'($urandom_range(3));
        return it;
    endfunction

    function automatic ssds_pkg::t_in_item tick_item(input logic [15:0] s,
                                                     input logic [1:0] vb);
        ssds_pkg::t_in_item it;
        it.mode            = 1'b0;
        it.seq_cmd         = 3'($urandom_range(7));
        it.off_ticks       = 16'($urandom);
        it.sensor_sample   = s;
        it.validation_bits = vb;
        return it;
    endfunction

    task automatic send_item(input ssds_pkg::t_in_item it);
        while ($urandom_range(99) < tx_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.payload <= it;
        do @(negedge i_clk); while (!in_ch.ready);
        @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {16'h0000, val};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    // drain, then reprogram the masks while the block is idle
    task automatic start_phase(input int tx_pct, input int rx_pct, input logic [15:0] trk,
                               input logic [15:0] vld, input logic [15:0] ctr);
        in_ch.valid <= 1'b0;
        do @(negedge i_clk); while (queued != 0);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        @(posedge i_clk);
        write_reg(ssds_pkg::REG_TRACKED, trk);
        write_reg(ssds_pkg::REG_VALID, vld);
        write_reg(ssds_pkg::REG_CENTER, ctr);
    endtask

    // commands followed by runs of ticks over a slowly moving sensor word, with random items mixed in
    task automatic run_sequences(input int n_items);
        int          sent;
        int          run;
        logic [15:0] level;
        logic [15:0] s;
        logic [1:0]  vb;
        logic [2:0]  c;
        logic [15:0] off;
        ssds_pkg::t_in_item it;
        sent  = 0;
        level = 16'($urandom);
        while (sent < n_items) begin
            if ($urandom_range(99) < 8) begin
                it.mode            = 1'($urandom_range(1));
                it.seq_cmd         = 3'($urandom_range(7));
                it.off_ticks       = 16'($urandom);
                it.sensor_sample   = 16'($urandom);
                it.validation_bits = 2'($urandom_range(3));
                send_item(it);
                sent++;
            end else begin
                c   = ($urandom_range(9) == 0) ? 3'($urandom_range(7, 5))
                                               : 3'($urandom_range(4));
                off = ($urandom_range(7) == 0) ? 16'($urandom) : 16'($urandom_range(6));
                send_item(cmd_item(c, off));
                sent++;
                if ($urandom_range(9) == 0) begin
                    send_item(cmd_item(3'($urandom_range(4)), 16'($urandom_range(3))));
                    sent++;
                end
                run = $urandom_range(4, 30);
                repeat (run) begin
                    if ($urandom_range(4) == 0)
                        level = ($urandom_range(1) == 0) ? 16'($urandom)
                                                         : level ^ (16'd1 << $urandom_range(15));
                    s  = ($urandom_range(9) == 0) ? 16'($urandom) : level;
                    vb = ($urandom_range(1) == 0) ? 2'b11 : 2'($urandom_range(3));
                    send_item(tick_item(s, vb));
                    sent++;
                end
            end
        end
    endtask

    initial begin : stimulus
        in_ch.valid   <= 1'b0;
        in_ch.payload <= '0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        i_rst_n       <= 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // ticks with no sequence, then an undefined command with nothing pending
        send_item(tick_item(16'hFFFF, 2'b11));
        send_item(tick_item(16'h0000, 2'b00));
        send_item(cmd_item(3'd7, 16'hFFFF));
        // init fills the store, then steady on broadcasts shifts
        send_item(cmd_item(ssds_pkg::CMD_INIT, 16'h0000));
        send_item(tick_item(16'h0000, 2'b00));
        send_item(tick_item(16'h03FF, 2'b11));
        send_item(tick_item(16'h03FF, 2'b11));
        send_item(tick_item(16'h0000, 2'b10));
        send_item(tick_item(16'h0000, 2'b01));
        // undefined code drops the pending blink, steady continues
        send_item(cmd_item(ssds_pkg::CMD_BLINK, 16'hFFFF));
        send_item(cmd_item(3'd5, 16'h0000));
        send_item(tick_item(16'h0155, 2'b11));
        // blink with zero off time
        send_item(cmd_item(ssds_pkg::CMD_BLINK, 16'h0000));
        send_item(tick_item(16'h0000, 2'b00));
        send_item(tick_item(16'h0000, 2'b00));
        send_item(tick_item(16'hFFFF, 2'b11));
        send_item(tick_item(16'hFFFF, 2'b11));
        // position adjust latches the last sample and waits
        send_item(cmd_item(ssds_pkg::CMD_ADJUST, 16'h8000));
        send_item(tick_item(16'h0000, 2'b00));
        send_item(tick_item(16'h1234, 2'b01));
        send_item(tick_item(16'hABCD, 2'b11));
        send_item(tick_item(16'h5555, 2'b10));
        // adjust detect slides over two samples
        send_item(cmd_item(ssds_pkg::CMD_DETECT, 16'h7FFF));
        send_item(tick_item(16'h0000, 2'b00));
        send_item(tick_item(16'hAAAA, 2'b11));
        send_item(tick_item(16'hAAAA, 2'b11));
        send_item(tick_item(16'h5555, 2'b00));

        start_phase(6, 66, 16'hFFFF, 16'h0000, 16'hFFFF);
        run_sequences(380);
        start_phase(66, 6, 16'h0000, 16'hFFFF, 16'h0000);
        run_sequences(380);
        start_phase(0, 0, 16'($urandom), 16'($urandom), 16'($urandom));
        pressure_on = 1'b1;
        run_sequences(380);

        in_ch.valid <= 1'b0;
        do @(negedge i_clk); while (queued != 0);
        repeat (8) @(posedge i_clk);
        if (errors == 0)
            $display("strobed_sensor_debounce_sequencer_core verification clean");
        else
            $display("strobed_sensor_debounce_sequencer_core verification failed");
        $finish;
    end

endmodule
